// ===== hdl/lpc_pkg.sv =====
// Shared types, constants and codes for the local pattern code unit.
// No dependencies; imported by every module of the unit.
package lpc_pkg;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned SAMPLE_N = 9;
	localparam int unsigned CODE_W   = 15;
	localparam int unsigned CENSUS_W = 9;
	localparam int unsigned GRAD_W   = 8;
	localparam int unsigned RANK_N   = 6;
	localparam int unsigned RANK_W   = 15;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef sample_t [SAMPLE_N-1:0] grid_t;
	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic [1:0] {
		OP_CENSUS   = 2'd0,
		OP_GRADIENT = 2'd1,
		OP_RANK     = 2'd2
	} opcode_t;

	// Neighbours of the centre, clockwise from top-left.
	localparam logic [3:0] RING_IDX [GRAD_W] = '{
		4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3
	};

endpackage

// ===== hdl/lpc_census.sv =====
// Census code: bit i set when nine times sample i exceeds the grid sum.
// Depends on lpc_pkg.
module lpc_census (
	input  lpc_pkg::grid_t               grid,
	output logic [lpc_pkg::CENSUS_W-1:0] code
);
	import lpc_pkg::*;

	logic [11:0] sum;

	always_comb begin
		sum = 12'(grid[0]) + 12'(grid[1]) + 12'(grid[2])
		    + 12'(grid[3]) + 12'(grid[4]) + 12'(grid[5])
		    + 12'(grid[6]) + 12'(grid[7]) + 12'(grid[8]);
	end

	for (genvar i = 0; i < CENSUS_W; i++) begin : g_bit
		logic [11:0] nine_x;
		// 9 * s as s * 8 + s
		assign nine_x = {1'b0, grid[i], 3'b000} + 12'(grid[i]);
		assign code[i] = nine_x > sum;
	end

endmodule

// ===== hdl/lpc_gradient.sv =====
// Gradient pattern: absolute differences of the ring to the centre,
// compared against their mean. Depends on lpc_pkg.
module lpc_gradient (
	input  lpc_pkg::grid_t             grid,
	output logic [lpc_pkg::GRAD_W-1:0] code
);
	import lpc_pkg::*;

	sample_t      diff [GRAD_W];
	logic [10:0]  diff_sum;
	sample_t      mean;

	for (genvar k = 0; k < GRAD_W; k++) begin : g_diff
		sample_t nb;
		assign nb = grid[RING_IDX[k]];
		assign diff[k] = (nb > grid[4]) ? (nb - grid[4]) : (grid[4] - nb);
	end

	always_comb begin
		diff_sum = 11'(diff[0]) + 11'(diff[1]) + 11'(diff[2]) + 11'(diff[3])
		         + 11'(diff[4]) + 11'(diff[5]) + 11'(diff[6]) + 11'(diff[7]);
		mean = diff_sum[10:3];
	end

	for (genvar k = 0; k < GRAD_W; k++) begin : g_bit
		assign code[k] = diff[k] > mean;
	end

endmodule

// ===== hdl/lpc_rank.sv =====
// Pairwise rank code over the first six samples, lexicographic pair order.
// Depends on lpc_pkg.
module lpc_rank (
	input  lpc_pkg::grid_t             grid,
	output logic [lpc_pkg::RANK_W-1:0] code
);
	import lpc_pkg::*;

	for (genvar a = 0; a < RANK_N - 1; a++) begin : g_a
		// first bit of the run that starts at sample a
		localparam int unsigned BASE = a * (2 * RANK_N - 1 - a) / 2;
		for (genvar b = a + 1; b < RANK_N; b++) begin : g_b
			assign code[BASE + b - a - 1] = grid[a] >= grid[b];
		end
	end

endmodule

// ===== hdl/local_pattern_code_unit_core.sv =====
// Top level of the local pattern code unit: input register, code logic, result register.
// Depends on lpc_pkg, lpc_census, lpc_gradient and lpc_rank.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+--------------------------------
//  item    | item_valid | item_stall | opcode, sample_0 .. sample_8
//  code    | code_valid | code_stall | pattern_code
//
// One item per cycle sustained while code_stall is low; an item passes the input register,
// then the result register, before its code is offered and can transfer.
// Reset clears both valid flags only; payload registers are not reset.
// A stall on the code side holds a full result register and, once the input
// register is also full, raises item_stall in the same cycle.
module local_pattern_code_unit_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [1:0]               opcode,
	input  lpc_pkg::sample_t         sample_0,
	input  lpc_pkg::sample_t         sample_1,
	input  lpc_pkg::sample_t         sample_2,
	input  lpc_pkg::sample_t         sample_3,
	input  lpc_pkg::sample_t         sample_4,
	input  lpc_pkg::sample_t         sample_5,
	input  lpc_pkg::sample_t         sample_6,
	input  lpc_pkg::sample_t         sample_7,
	input  lpc_pkg::sample_t         sample_8,
	output logic                     code_valid,
	input  logic                     code_stall,
	output lpc_pkg::code_t           pattern_code
);
	import lpc_pkg::*;

	logic        valid_s1;
	logic [1:0]  opcode_s1;
	grid_t       grid_s1;
	logic        valid_s2;
	code_t       code_s2;

	logic        load_s2;
	logic        load_s1;
	logic [CENSUS_W-1:0] census_code;
	logic [GRAD_W-1:0]   grad_code;
	logic [RANK_W-1:0]   rank_code;
	code_t       code_next;

	assign load_s2    = !valid_s2 || !code_stall;
	assign item_stall = valid_s1 && !load_s2;
	assign load_s1    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || load_s2) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			opcode_s1 <= opcode;
			grid_s1   <= {sample_8, sample_7, sample_6, sample_5, sample_4,
			              sample_3, sample_2, sample_1, sample_0};
		end
	end

	lpc_census u_census (
		.grid (grid_s1),
		.code (census_code)
	);

	lpc_gradient u_gradient (
		.grid (grid_s1),
		.code (grad_code)
	);

	lpc_rank u_rank (
		.grid (grid_s1),
		.code (rank_code)
	);

	always_comb begin
		case (opcode_s1)
			OP_CENSUS:   code_next = CODE_W'(census_code);
			OP_GRADIENT: code_next = CODE_W'(grad_code);
			OP_RANK:     code_next = CODE_W'(rank_code);
			default:     code_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// hold the result while stalled; take a new one only with a full input register
	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			code_s2 <= code_next;
		end
	end

	assign code_valid   = valid_s2;
	assign pattern_code = code_s2;

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item_stall raised with an empty input register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && code_stall |=> valid_s1 && $stable(grid_s1)
		&& $stable(opcode_s1))
		else $error("input register changed while blocked");

	a_s2_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a registered item");

	a_unused_op_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_s2 && !(opcode_s1 == OP_CENSUS || opcode_s1 == OP_GRADIENT
		|| opcode_s1 == OP_RANK) |=> pattern_code == '0)
		else $error("unused opcode gave a non-zero code");

	a_narrow_codes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_s2 && opcode_s1 == OP_GRADIENT
		|=> pattern_code[CODE_W-1:GRAD_W] == '0)
		else $error("gradient code wider than eight bits");

endmodule
